// ----- hdl/chacha20_stream_xor_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef CHACHA20_STREAM_XOR_MACROS_SVH
`define CHACHA20_STREAM_XOR_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define CSX_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define CSX_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/csx_pkg.sv -----
package csx_pkg;

  typedef logic [2:0]  cfg_idx_t;
  typedef logic [3:0]  word_idx_t;
  typedef logic [31:0] word_t;

  // register map
  localparam cfg_idx_t CFG_KEY_01   = 3'd0;
  localparam cfg_idx_t CFG_KEY_23   = 3'd1;
  localparam cfg_idx_t CFG_KEY_45   = 3'd2;
  localparam cfg_idx_t CFG_KEY_67   = 3'd3;
  localparam cfg_idx_t CFG_NONCE_01 = 3'd4;
  localparam cfg_idx_t CFG_NONCE_2  = 3'd5;
  localparam cfg_idx_t CFG_START    = 3'd6;

  // "expand 32-byte k"
  localparam word_t SIGMA_0 = 32'h6170_7865;
  localparam word_t SIGMA_1 = 32'h3320_646e;
  localparam word_t SIGMA_2 = 32'h7962_2d32;
  localparam word_t SIGMA_3 = 32'h6b20_6574;

  localparam logic [6:0] BLOCK_BYTES = 7'd64;
  localparam logic [3:0] LAST_ROUND  = 4'd9;
  localparam logic [2:0] LAST_QR     = 3'd7;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_INIT   = 10'b00_0000_0010,
    ST_RD_AB  = 10'b00_0000_0100,
    ST_RD_CD  = 10'b00_0000_1000,
    ST_LAT_CD = 10'b00_0001_0000,
    ST_MIX    = 10'b00_0010_0000,
    ST_WB     = 10'b00_0100_0000,
    ST_FIN    = 10'b00_1000_0000,
    ST_KS_RD  = 10'b01_0000_0000,
    ST_KS_OUT = 10'b10_0000_0000
  } state_t;

  // word indices {a, b, c, d} of quarter round q within a double round
  function automatic logic [15:0] qr_sel(input logic [2:0] q);
    logic [15:0] r;
    case (q)
      3'd0:    r = {4'd0, 4'd4, 4'd8,  4'd12};
      3'd1:    r = {4'd1, 4'd5, 4'd9,  4'd13};
      3'd2:    r = {4'd2, 4'd6, 4'd10, 4'd14};
      3'd3:    r = {4'd3, 4'd7, 4'd11, 4'd15};
      3'd4:    r = {4'd0, 4'd5, 4'd10, 4'd15};
      3'd5:    r = {4'd1, 4'd6, 4'd11, 4'd12};
      3'd6:    r = {4'd2, 4'd7, 4'd8,  4'd13};
      default: r = {4'd3, 4'd4, 4'd9,  4'd14};
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/chacha20_stream_xor.sv -----
// Channel | Handshake            | Payload                     | Dir
// in      | in_valid / in_ready  | in_data_byte, in_restart,   | in
//         |                      | in_last_in                  |
// out     | out_valid / out_ready| out_byte, out_last_out      | out
// cfg     | cfg_we               | cfg_index, cfg_wdata        | in
//
// A byte steps through accept, keystream word read and output load while the
// current keystream block lasts. Starting a new block first loads the input
// words into the working RAM, then runs 80 quarter rounds, each with two RAM
// reads, one latch, four add/xor/rotate steps and four write-backs through the
// single RAM write port, and finally adds the input words back.
// Reset (rst_n low, synchronous) clears config and the counter to zero and
// forces a new block on the first byte. The output register lets a new byte be
// accepted while the previous result waits; a stalled output only holds the
// final load step.
module chacha20_stream_xor (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_data_byte,
  input  logic               in_restart,
  input  logic               in_last_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               out_last_out,
  input  logic               cfg_we,
  input  csx_pkg::cfg_idx_t  cfg_index,
  input  logic [63:0]        cfg_wdata
);
  import csx_pkg::*;

  // configuration
  logic [63:0] key01_r, key23_r, key45_r, key67_r, nonce01_r, start_r;
  logic [31:0] nonce2_r;

  // control and block state
  state_t      state_r, state_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [2:0]  qr_r, qr_nxt;
  logic [3:0]  round_r, round_nxt;
  logic [6:0]  pos_r, pos_nxt;
  word_t       ctr_lo_r, ctr_lo_nxt, ctr_hi_r, ctr_hi_nxt;
  logic [7:0]  data_r, data_nxt;
  logic        last_r, last_nxt;
  word_t       qa_r, qb_r, qc_r, qd_r, qa_nxt, qb_nxt, qc_nxt, qd_nxt;
  logic        out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;

  // working RAM (two read ports, one write port) and keystream RAM
  word_t       work_mem [16];
  word_t       ks_mem [16];
  word_t       rd0_r, rd1_r, ks_word_r;
  word_idx_t   rd_addr0, rd_addr1, wr_addr, ks_waddr, fin_waddr;
  word_t       wr_data, ks_wdata;
  logic        wr_en, ks_we;

  word_t       init_words [16];
  logic [15:0] sel;
  word_idx_t   ia, ib, ic, id;
  word_t       sum, mixed;
  word_t       ctr_lo_inc;
  logic        in_xfer, out_xfer, out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid_r && out_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last_out = out_last_r;

  assign sel = qr_sel(qr_r);
  assign ia  = sel[15:12];
  assign ib  = sel[11:8];
  assign ic  = sel[7:4];
  assign id  = sel[3:0];

  assign fin_waddr  = 4'(cnt_r - 5'd1);
  assign ctr_lo_inc = ctr_lo_r + 32'd1;

  // block input words; word 13 is nonce word 0 plus the counter high half
  always_comb begin
    init_words[0]  = SIGMA_0;
    init_words[1]  = SIGMA_1;
    init_words[2]  = SIGMA_2;
    init_words[3]  = SIGMA_3;
    init_words[4]  = key01_r[31:0];
    init_words[5]  = key01_r[63:32];
    init_words[6]  = key23_r[31:0];
    init_words[7]  = key23_r[63:32];
    init_words[8]  = key45_r[31:0];
    init_words[9]  = key45_r[63:32];
    init_words[10] = key67_r[31:0];
    init_words[11] = key67_r[63:32];
    init_words[12] = ctr_lo_r;
    init_words[13] = ctr_hi_r;
    init_words[14] = nonce01_r[63:32];
    init_words[15] = nonce2_r;
  end

  // config writes; index 7 is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key01_r   <= '0;
      key23_r   <= '0;
      key45_r   <= '0;
      key67_r   <= '0;
      nonce01_r <= '0;
      nonce2_r  <= '0;
      start_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_01:   key01_r   <= cfg_wdata;
        CFG_KEY_23:   key23_r   <= cfg_wdata;
        CFG_KEY_45:   key45_r   <= cfg_wdata;
        CFG_KEY_67:   key67_r   <= cfg_wdata;
        CFG_NONCE_01: nonce01_r <= cfg_wdata;
        CFG_NONCE_2:  nonce2_r  <= cfg_wdata[31:0];
        CFG_START:    start_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    qr_nxt        = qr_r;
    round_nxt     = round_r;
    pos_nxt       = pos_r;
    ctr_lo_nxt    = ctr_lo_r;
    ctr_hi_nxt    = ctr_hi_r;
    data_nxt      = data_r;
    last_nxt      = last_r;
    qa_nxt        = qa_r;
    qb_nxt        = qb_r;
    qc_nxt        = qc_r;
    qd_nxt        = qd_r;
    out_valid_nxt = out_xfer ? 1'b0 : out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    rd_addr0      = ia;
    rd_addr1      = ib;
    wr_en         = 1'b0;
    wr_addr       = cnt_r[3:0];
    wr_data       = init_words[cnt_r[3:0]];
    ks_we         = 1'b0;
    ks_waddr      = fin_waddr;
    ks_wdata      = rd0_r + init_words[fin_waddr];
    sum           = '0;
    mixed         = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          data_nxt  = in_data_byte;
          last_nxt  = in_last_in;
          cnt_nxt   = '0;
          qr_nxt    = '0;
          round_nxt = '0;
          if (in_restart) begin
            ctr_lo_nxt = start_r[31:0];
            ctr_hi_nxt = nonce01_r[31:0] + start_r[63:32];
            pos_nxt    = BLOCK_BYTES;
            state_nxt  = ST_INIT;
          end else if (pos_r[6]) begin
            state_nxt = ST_INIT;
          end else begin
            state_nxt = ST_KS_RD;
          end
        end
      end
      ST_INIT: begin
        wr_en = 1'b1;
        if (cnt_r[3:0] == 4'd15) begin
          cnt_nxt   = '0;
          state_nxt = ST_RD_AB;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      ST_RD_AB: begin
        state_nxt = ST_RD_CD;
      end
      ST_RD_CD: begin
        qa_nxt    = rd0_r;
        qb_nxt    = rd1_r;
        rd_addr0  = ic;
        rd_addr1  = id;
        state_nxt = ST_LAT_CD;
      end
      ST_LAT_CD: begin
        qc_nxt    = rd0_r;
        qd_nxt    = rd1_r;
        cnt_nxt   = '0;
        state_nxt = ST_MIX;
      end
      ST_MIX: begin
        case (cnt_r[1:0])
          2'd0: begin
            sum    = qa_r + qb_r;
            mixed  = qd_r ^ sum;
            qa_nxt = sum;
            qd_nxt = {mixed[15:0], mixed[31:16]};
          end
          2'd1: begin
            sum    = qc_r + qd_r;
            mixed  = qb_r ^ sum;
            qc_nxt = sum;
            qb_nxt = {mixed[19:0], mixed[31:20]};
          end
          2'd2: begin
            sum    = qa_r + qb_r;
            mixed  = qd_r ^ sum;
            qa_nxt = sum;
            qd_nxt = {mixed[23:0], mixed[31:24]};
          end
          default: begin
            sum    = qc_r + qd_r;
            mixed  = qb_r ^ sum;
            qc_nxt = sum;
            qb_nxt = {mixed[24:0], mixed[31:25]};
          end
        endcase
        if (cnt_r[1:0] == 2'd3) begin
          cnt_nxt   = '0;
          state_nxt = ST_WB;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      ST_WB: begin
        wr_en = 1'b1;
        case (cnt_r[1:0])
          2'd0: begin
            wr_addr = ia;
            wr_data = qa_r;
          end
          2'd1: begin
            wr_addr = ib;
            wr_data = qb_r;
          end
          2'd2: begin
            wr_addr = ic;
            wr_data = qc_r;
          end
          default: begin
            wr_addr = id;
            wr_data = qd_r;
          end
        endcase
        if (cnt_r[1:0] == 2'd3) begin
          cnt_nxt = '0;
          if (qr_r == LAST_QR) begin
            qr_nxt = '0;
            if (round_r == LAST_ROUND) begin
              round_nxt = '0;
              state_nxt = ST_FIN;
            end else begin
              round_nxt = round_r + 4'd1;
              state_nxt = ST_RD_AB;
            end
          end else begin
            qr_nxt    = qr_r + 3'd1;
            state_nxt = ST_RD_AB;
          end
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      ST_FIN: begin
        // read word n while word n-1 gets its input word added back
        rd_addr0 = cnt_r[3:0];
        ks_we    = (cnt_r != 5'd0);
        if (cnt_r[4]) begin
          cnt_nxt    = '0;
          pos_nxt    = '0;
          ctr_lo_nxt = ctr_lo_inc;
          ctr_hi_nxt = (ctr_lo_inc == 32'd0) ? ctr_hi_r + 32'd1 : ctr_hi_r;
          state_nxt  = ST_KS_RD;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      ST_KS_RD: begin
        state_nxt = ST_KS_OUT;
      end
      ST_KS_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = last_r;
          case (pos_r[1:0])
            2'd0:    out_byte_nxt = data_r ^ ks_word_r[7:0];
            2'd1:    out_byte_nxt = data_r ^ ks_word_r[15:8];
            2'd2:    out_byte_nxt = data_r ^ ks_word_r[23:16];
            default: out_byte_nxt = data_r ^ ks_word_r[31:24];
          endcase
          pos_nxt   = pos_r + 7'd1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      qr_r        <= '0;
      round_r     <= '0;
      pos_r       <= BLOCK_BYTES;
      ctr_lo_r    <= '0;
      ctr_hi_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      qr_r        <= qr_nxt;
      round_r     <= round_nxt;
      pos_r       <= pos_nxt;
      ctr_lo_r    <= ctr_lo_nxt;
      ctr_hi_r    <= ctr_hi_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r     <= data_nxt;
    last_r     <= last_nxt;
    qa_r       <= qa_nxt;
    qb_r       <= qb_nxt;
    qc_r       <= qc_nxt;
    qd_r       <= qd_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  // working RAM
  always_ff @(posedge clk) begin
    if (wr_en) begin
      work_mem[wr_addr] <= wr_data;
    end
    rd0_r <= work_mem[rd_addr0];
    rd1_r <= work_mem[rd_addr1];
  end

  // keystream RAM
  always_ff @(posedge clk) begin
    if (ks_we) begin
      ks_mem[ks_waddr] <= ks_wdata;
    end
    ks_word_r <= ks_mem[pos_r[5:2]];
  end

`include "chacha20_stream_xor_macros.svh"

  `CSX_ASSERT_IMP(a_ks_pos_in_block, state_r == ST_KS_RD, !pos_r[6], "keystream read past block")
  `CSX_ASSERT_NXT(a_restart_new_block, in_xfer && in_restart,
                  state_r == ST_INIT && pos_r == BLOCK_BYTES, "restart did not force block")
  `CSX_ASSERT_NXT(a_fin_done, state_r == ST_FIN && cnt_r[4],
                  state_r == ST_KS_RD && pos_r == 7'd0, "block finish did not rewind pos")
  `CSX_ASSERT_NXT(a_out_load, state_r == ST_KS_OUT && out_free,
                  out_valid_r && state_r == ST_IDLE, "result not loaded")

endmodule

// ----- bench/tb_chacha20_stream_xor.sv -----
module tb_chacha20_stream_xor;
  import csx_pkg::*;

  // Input items in the random part; the run stops feeding once this is reached.
  localparam int ITEM_COUNT = 1000;
  // A new block costs far more than a byte and this stimulus makes well under a
  // hundred of them. Even with both sides stalling, a correct run stays far
  // below this limit, so it leaves a wide margin.
  localparam int CYCLE_LIMIT = 1_000_000;
  // Quiet cycles after the last result before a config write or the verdict.
  localparam int SETTLE_CYCLES = 20;
  // Index past the register map: the block must drop writes to it.
  localparam cfg_idx_t CFG_UNMAPPED = 3'd7;
  // Random bytes are no longer stalled from this point on.
  localparam int CALM_TAIL = 150;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } cipher_out_t;

  // Predicts the XOR stream and keeps the expected output bytes in order.
  class cipher_scoreboard;
    bit [63:0]   regs [7];
    bit [31:0]   ks_words [16];
    bit [31:0]   mix [16];
    bit [6:0]    pos;
    bit [31:0]   ctr_lo;
    bit [31:0]   ctr_hi;
    cipher_out_t expected_q [$];
    int          errors;

    function void reset_state();
      foreach (regs[i]) regs[i] = '0;
      errors = 0;
      reload_counter();
    endfunction

    function void write_reg(cfg_idx_t idx, bit [63:0] val);
      if (idx > CFG_START) return;
      if (idx == CFG_NONCE_2) val[63:32] = '0;
      regs[idx] = val;
    endfunction

    // Word 13 is nonce word 0 plus the counter high half, not the plain nonce.
    function void reload_counter();
      ctr_lo = regs[CFG_START][31:0];
      ctr_hi = regs[CFG_NONCE_01][31:0] + regs[CFG_START][63:32];
      pos    = BLOCK_BYTES;
    endfunction

    function bit [31:0] rotl(bit [31:0] v, int s);
      return (v << s) | (v >> (32 - s));
    endfunction

    function void quarter(int a, int b, int c, int d);
      mix[a] += mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 16);
      mix[c] += mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 12);
      mix[a] += mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 8);
      mix[c] += mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 7);
    endfunction

    function void gen_block();
      bit [31:0] init [16];
      init[0] = SIGMA_0;
      init[1] = SIGMA_1;
      init[2] = SIGMA_2;
      init[3] = SIGMA_3;
      for (int i = 0; i < 4; i++) begin
        init[4 + 2 * i] = regs[i][31:0];
        init[5 + 2 * i] = regs[i][63:32];
      end
      init[12] = ctr_lo;
      init[13] = ctr_hi;
      init[14] = regs[CFG_NONCE_01][63:32];
      init[15] = regs[CFG_NONCE_2][31:0];
      mix = init;
      for (int r = 0; r < 10; r++) begin
        quarter(0, 4, 8, 12);
        quarter(1, 5, 9, 13);
        quarter(2, 6, 10, 14);
        quarter(3, 7, 11, 15);
        quarter(0, 5, 10, 15);
        quarter(1, 6, 11, 12);
        quarter(2, 7, 8, 13);
        quarter(3, 4, 9, 14);
      end
      for (int i = 0; i < 16; i++) ks_words[i] = mix[i] + init[i];
      ctr_lo++;
      if (ctr_lo == 0) ctr_hi++;
    endfunction

    function void note_byte(bit [7:0] d, bit rs, bit lst);
      bit [7:0]    ks;
      cipher_out_t e;
      if (rs) reload_counter();
      if (pos >= BLOCK_BYTES) begin
        gen_block();
        pos = 0;
      end
      ks = ks_words[pos[5:2]][{pos[1:0], 3'b000} +: 8];
      e.data = d ^ ks;
      e.last = lst;
      expected_q.push_back(e);
      pos = pos + 7'd1;
    endfunction

    function void check_byte(logic [7:0] b, logic lst);
      cipher_out_t e;
      if (expected_q.size() == 0) begin
        $error("out transfer with nothing expected: out_byte %h", b);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (b !== e.data) begin
        $error("out_byte: expected %h, got %h", e.data, b);
        errors++;
      end
      if (lst !== e.last) begin
        $error("out_last_out: expected %b, got %b", e.last, lst);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_restart;
  logic        in_last_in;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        out_last_out;
  logic        cfg_we;
  cfg_idx_t    cfg_index;
  logic [63:0] cfg_wdata;

  cipher_scoreboard sb;
  int items_sent = 0;
  int cycle_count = 0;
  int stall_left = 0;
  bit idle_on = 1'b1;   // random stalls on both channels while set

  chacha20_stream_xor uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_restart   (in_restart),
    .in_last_in   (in_last_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_last_out (out_last_out),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: ready drops in random bursts while idling is on.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready = 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 9);
      out_ready = 1'b0;
    end else begin
      out_ready = 1'b1;
    end
  end

  // Every out transfer is checked against the oldest expected byte.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_byte(out_byte, out_last_out);
  end

  // Called at a falling edge; returns at the falling edge after the transfer
  // with valid still high, so back-to-back bytes need no gap.
  task automatic send_byte(input logic [7:0] d, input logic rs, input logic lst);
    // the tail of the run goes without stalls
    if (items_sent >= ITEM_COUNT - CALM_TAIL) idle_on = 1'b0;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid     = 1'b1;
    in_data_byte = d;
    in_restart   = rs;
    in_last_in   = lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_byte(d, rs, lst);
    items_sent++;
    @(negedge clk);
  endtask

  // Holds the sender until every expected byte is out and the block is quiet.
  task automatic wait_idle();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input logic [63:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // A buffer normally opens with a restart and closes with last; stray
  // restarts and last marks inside it are the noise.
  task automatic send_buffer(input int len, input bit lead_restart);
    logic rs;
    logic lst;
    for (int k = 0; k < len && items_sent < ITEM_COUNT; k++) begin
      rs  = (k == 0) ? lead_restart : ($urandom_range(0, 39) == 0);
      lst = (k == len - 1) ? 1'b1 : ($urandom_range(0, 19) == 0);
      send_byte(8'($urandom_range(0, 255)), rs, lst);
    end
  endtask

  // Mostly within one block; some buffers cross several block boundaries.
  function automatic int buffer_len();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(65, 200);
      1:       return 1;
      default: return $urandom_range(2, 64);
    endcase
  endfunction

  // Extremes and a low half just short of wrapping, so counter carries occur.
  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return {32'($urandom()), 32'hFFFF_FFFF - 32'($urandom_range(0, 2))};
      default: return {32'($urandom()), 32'($urandom())};
    endcase
  endfunction

  initial begin
    int buffers;
    sb = new();
    sb.reset_state();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data_byte = '0;
    in_restart   = 1'b0;
    in_last_in   = 1'b0;
    out_ready    = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_KEY_01;
    cfg_wdata    = '0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // All-zero config; the first byte makes a block with no restart.
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'h55, 1'b0, 1'b0);
    // Restart mid-block: counter reloads to zero, block 0 comes back.
    send_byte(8'hAA, 1'b1, 1'b0);
    send_byte(8'h3C, 1'b0, 1'b1);
    wait_idle();

    // Every register at all ones; the unmapped index must change nothing.
    cfg_write(CFG_KEY_01, '1);
    cfg_write(CFG_KEY_23, '1);
    cfg_write(CFG_KEY_45, '1);
    cfg_write(CFG_KEY_67, '1);
    cfg_write(CFG_NONCE_01, '1);
    cfg_write(CFG_NONCE_2, '1);
    cfg_write(CFG_START, '1);
    cfg_write(CFG_UNMAPPED, 64'h0123_4567_89AB_CDEF);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'h80, 1'b0, 1'b0);
    wait_idle();

    // Mixed patterns; upper bits of nonce word 2 must be dropped.
    cfg_write(CFG_KEY_01, 64'h0706_0504_0302_0100);
    cfg_write(CFG_KEY_23, 64'h0F0E_0D0C_0B0A_0908);
    cfg_write(CFG_KEY_45, 64'h0);
    cfg_write(CFG_KEY_67, 64'h8000_0000_0000_0001);
    cfg_write(CFG_NONCE_01, 64'h5555_5555_AAAA_AAAA);
    cfg_write(CFG_NONCE_2, 64'hFFFF_FFFF_0000_0001);
    cfg_write(CFG_START, 64'h0000_0000_FFFF_FFFF);
    send_byte(8'h01, 1'b1, 1'b0);
    send_byte(8'hFE, 1'b0, 1'b1);

    // Random phases: drain, rewrite a few registers (no restart is forced,
    // so key changes can land mid-stream), then send some buffers.
    items_sent = 0;
    while (items_sent < ITEM_COUNT) begin
      wait_idle();
      idle_on = (items_sent < ITEM_COUNT - CALM_TAIL) && ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(0, 3)) cfg_write(cfg_idx_t'($urandom_range(0, 7)), pick_value());
      buffers = $urandom_range(1, 3);
      repeat (buffers) send_buffer(buffer_len(), $urandom_range(0, 3) != 0);
    end

    wait_idle();
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/csx_pkg.sv
hdl/chacha20_stream_xor.sv
bench/tb_chacha20_stream_xor.sv
